// File: src/generational_handle_pool_macros.svh
// Assertion macros for the handle pool. Each expects clk and rst_n in scope.
`ifndef GENERATIONAL_HANDLE_POOL_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define GHP_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: label");

// Next-cycle implication.
`define GHP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: label");

`else

`define GHP_ASSERT_IMP(label, cond, expr)
`define GHP_ASSERT_NEXT(label, cond, expr)

`endif

`endif

// File: src/ghp_pkg.sv
package ghp_pkg;

    localparam int GEN_W   = 32;
    localparam int INDEX_W = 8;
    localparam int LIVE_W  = 9;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [INDEX_W-1:0] handle_index;
        logic [GEN_W-1:0]   handle_generation;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] out_index;
        logic [GEN_W-1:0]   out_generation;
        logic [LIVE_W-1:0]  live_count;
    } rsp_t;

endpackage

// File: src/generational_handle_pool.sv
// Generational handle pool: SLOT_COUNT slots, each with an alive bit and a 32-bit
// generation. Create takes the lowest free slot, destroy frees a slot named by a
// valid handle, check reports whether a handle is valid; every item returns one
// result with the live count. One item is in work at a time. A create scans the
// alive bits from slot 0, one slot per cycle, to find the lowest free slot, then
// reads and updates that slot; on a full pool it scans every slot and goes
// straight to the update. Destroy and check first do the registered read of the
// single-port generation memory, then the update. An unused op code goes straight
// to the update. A finished result waits in an output register, so the next item
// is accepted while it is held.
`include "generational_handle_pool_macros.svh"

module generational_handle_pool #(
    parameter int SLOT_COUNT = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ghp_pkg::req_t   in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output ghp_pkg::rsp_t   out_item
);

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(SLOT_COUNT - 1);
    localparam logic [ghp_pkg::LIVE_W-1:0] LIVE_MAX = ghp_pkg::LIVE_W'(SLOT_COUNT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_EXEC = 2'd3;

    logic [1:0]                   state_reg, state_next;
    ghp_pkg::req_t                req_reg, req_next;
    logic [SLOT_IDX_W-1:0]        addr_reg, addr_next;
    logic [SLOT_IDX_W-1:0]        scan_reg, scan_next;
    logic                         full_reg, full_next;
    logic [SLOT_COUNT-1:0]        alive_reg, alive_next;
    logic [SLOT_COUNT-1:0]        written_reg, written_next;
    logic [ghp_pkg::LIVE_W-1:0]   live_reg, live_next;
    logic                         out_valid_reg, out_valid_next;
    ghp_pkg::rsp_t                out_item_reg, out_item_next;

    logic [ghp_pkg::GEN_W-1:0]    gen_mem [SLOT_COUNT];
    logic [ghp_pkg::GEN_W-1:0]    rd_gen_reg;
    logic                         rd_written_reg;

    logic [ghp_pkg::GEN_W-1:0]    slot_gen;
    logic [ghp_pkg::GEN_W-1:0]    gen_inc;
    logic [ghp_pkg::GEN_W-1:0]    gen_new;
    logic                         gen_match;
    logic                         range_ok;
    logic                         handle_ok;
    logic                         out_free;
    logic                         exec_fire;
    logic                         create_ok;
    logic                         destroy_ok;
    logic                         slot_write;
    ghp_pkg::rsp_t                rsp;

    // Shared generation unit: one increment serves create and destroy, one compare serves destroy and check.
    always_comb
    begin
        slot_gen   = rd_written_reg ? rd_gen_reg : '0;
        gen_inc    = slot_gen + ghp_pkg::GEN_W'(1);
        gen_match  = (slot_gen == req_reg.handle_generation);
        range_ok   = ({1'b0, req_reg.handle_index} < LIVE_MAX);
        handle_ok  = (req_reg.handle_generation != '0) && range_ok
                     && alive_reg[addr_reg] && gen_match;
        out_free   = !out_valid_reg || out_ready;
        exec_fire  = (state_reg == ST_EXEC) && out_free;
        create_ok  = (req_reg.op == ghp_pkg::OP_CREATE) && !full_reg;
        destroy_ok = (req_reg.op == ghp_pkg::OP_DESTROY) && handle_ok;
        slot_write = exec_fire && (create_ok || destroy_ok);
        // Skip generation zero on create.
        gen_new    = (create_ok && (gen_inc == '0)) ? ghp_pkg::GEN_W'(1) : gen_inc;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        scan_next      = scan_reg;
        full_next      = full_reg;
        alive_next     = alive_reg;
        written_next   = written_reg;
        live_next      = live_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (slot_write)
        begin
            alive_next[addr_reg]   = create_ok;
            written_next[addr_reg] = 1'b1;
        end
        if (exec_fire && create_ok && (live_reg < LIVE_MAX))
        begin
            live_next = live_reg + ghp_pkg::LIVE_W'(1);
        end
        else if (exec_fire && destroy_ok && (live_reg != '0))
        begin
            live_next = live_reg - ghp_pkg::LIVE_W'(1);
        end

        rsp.ok             = create_ok || destroy_ok
                             || ((req_reg.op == ghp_pkg::OP_CHECK) && handle_ok);
        rsp.out_index      = create_ok ? ghp_pkg::INDEX_W'(addr_reg) : '0;
        rsp.out_generation = create_ok ? gen_new : '0;
        rsp.live_count     = live_next;

        if (exec_fire)
        begin
            out_valid_next = 1'b1;
            out_item_next  = rsp;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_item;
                    full_next = 1'b0;
                    scan_next = '0;
                    addr_next = in_item.handle_index[SLOT_IDX_W-1:0];
                    unique case (in_item.op)
                        ghp_pkg::OP_CREATE:  state_next = ST_SCAN;
                        ghp_pkg::OP_DESTROY: state_next = ST_READ;
                        ghp_pkg::OP_CHECK:   state_next = ST_READ;
                        default:             state_next = ST_EXEC;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Advance one slot per cycle until a free one turns up or the last slot is reached.
                if (!alive_reg[scan_reg])
                begin
                    addr_next  = scan_reg;
                    state_next = ST_READ;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    full_next  = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_IDX_W'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // Hold here until the output register is free.
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            full_reg      <= 1'b0;
            scan_reg      <= '0;
            alive_reg     <= '0;
            written_reg   <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            full_reg      <= full_next;
            scan_reg      <= scan_next;
            alive_reg     <= alive_next;
            written_reg   <= written_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        out_item_reg <= out_item_next;
    end

    // Generation memory: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (slot_write)
        begin
            gen_mem[addr_reg] <= gen_new;
        end
        if (state_reg == ST_READ)
        begin
            rd_gen_reg     <= gen_mem[addr_reg];
            rd_written_reg <= written_reg[addr_reg];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `GHP_ASSERT_IMP(a_live_bound, 1'b1, live_reg <= LIVE_MAX)
    `GHP_ASSERT_IMP(a_create_gen_nonzero, exec_fire && create_ok, gen_new != '0)
    `GHP_ASSERT_NEXT(a_create_count, exec_fire && create_ok, live_reg == $past(live_reg) + ghp_pkg::LIVE_W'(1))
    `GHP_ASSERT_NEXT(a_destroy_count, exec_fire && destroy_ok, live_reg == $past(live_reg) - ghp_pkg::LIVE_W'(1))

endmodule

// File: tb/sv/generational_handle_pool_test.sv
`timescale 1ns / 1ps

module generational_handle_pool_test;

    localparam int SLOTS = 64;
    localparam int RANDOM_ITEMS = 950;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ghp_pkg::req_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ghp_pkg::rsp_t out_item;

    generational_handle_pool #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

    // Predicted pool contents, updated as each item is accepted
    bit                         slot_alive [SLOTS];
    logic [ghp_pkg::GEN_W-1:0]  slot_gen [SLOTS];
    logic [ghp_pkg::LIVE_W-1:0] live_slots;

    ghp_pkg::req_t pending_requests[$];
    ghp_pkg::rsp_t pending_results[$];
    int   send_gap = 0;
    int   recv_gap = 0;
    int   failures = 0;
    bit   quiet = 1'b0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic ghp_pkg::rsp_t pool_response(ghp_pkg::req_t r);
        ghp_pkg::rsp_t rsp;
        bit valid;
        logic [ghp_pkg::GEN_W-1:0] g;
        rsp = '0;
        valid = r.handle_generation != '0 && r.handle_index < SLOTS
            && slot_alive[r.handle_index] && slot_gen[r.handle_index] == r.handle_generation;
        case (r.op)
            ghp_pkg::OP_CREATE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_alive[i]) begin
                        g = slot_gen[i] + 1'b1;
                        if (g == '0)
                            g = ghp_pkg::GEN_W'(1);
                        slot_gen[i] = g;
                        slot_alive[i] = 1'b1;
                        live_slots = live_slots + 1'b1;
                        rsp.ok = 1'b1;
                        rsp.out_index = ghp_pkg::INDEX_W'(i);
                        rsp.out_generation = g;
                        break;
                    end
                end
            end
            ghp_pkg::OP_DESTROY: begin
                if (valid) begin
                    slot_alive[r.handle_index] = 1'b0;
                    slot_gen[r.handle_index] = slot_gen[r.handle_index] + 1'b1;
                    live_slots = live_slots - 1'b1;
                    rsp.ok = 1'b1;
                end
            end
            ghp_pkg::OP_CHECK: rsp.ok = valid;
            default: ;
        endcase
        rsp.live_count = live_slots;
        return rsp;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ghp_pkg::req_t make_req(logic [1:0] op,
                                               logic [ghp_pkg::INDEX_W-1:0] idx,
                                               logic [ghp_pkg::GEN_W-1:0] gen);
        ghp_pkg::req_t r;
        r.op = op;
        r.handle_index = idx;
        r.handle_generation = gen;
        return r;
    endfunction

    task automatic push_request(ghp_pkg::req_t r);
        while (pending_requests.size() >= 4)
            @(posedge clk);
        pending_requests.push_back(r);
    endtask

    task automatic push_random_request(int create_pct);
        int r;
        int s;
        int start;
        ghp_pkg::req_t q;
        r = $urandom_range(99);
        q = make_req(ghp_pkg::OP_CREATE, ghp_pkg::INDEX_W'($urandom), $urandom);
        if (r >= create_pct) begin
            if (r >= 95) begin
                q.op = OP_UNUSED;
            end else begin
                q.op = ($urandom_range(2) == 0) ? ghp_pkg::OP_CHECK : ghp_pkg::OP_DESTROY;
                // aim at a live slot, starting the search at a random place
                s = -1;
                start = $urandom_range(SLOTS - 1);
                for (int k = 0; k < SLOTS; k++) begin
                    if (s < 0 && slot_alive[(start + k) % SLOTS])
                        s = (start + k) % SLOTS;
                end
                if (s < 0)
                    s = $urandom_range(SLOTS - 1);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: begin
                        q.handle_index = ghp_pkg::INDEX_W'(s);
                        q.handle_generation = slot_gen[s];
                    end
                    6: begin
                        q.handle_index = ghp_pkg::INDEX_W'(s);
                        q.handle_generation = slot_gen[s] - $urandom_range(1, 3);
                    end
                    7: begin
                        q.handle_index = ghp_pkg::INDEX_W'(s);
                        q.handle_generation = '0;
                    end
                    8: begin
                        q.handle_index = ghp_pkg::INDEX_W'($urandom_range(SLOTS, 255));
                        if ($urandom_range(1))
                            q.handle_generation = slot_gen[s];
                    end
                    default: ;
                endcase
            end
        end
        push_request(q);
    endtask

    // Driver: predict on acceptance, then present the next item after its gap
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready)
                pending_results.push_back(pool_response(in_item));
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_requests.size() > 0) begin
                    in_valid <= 1'b1;
                    in_item <= pending_requests.pop_front();
                    send_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(string field, logic [ghp_pkg::GEN_W-1:0] want,
                                 logic [ghp_pkg::GEN_W-1:0] got);
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        failures++;
    endtask

    // Monitor: compare each result with the oldest prediction, then wait a random gap, often none
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    failures++;
                end else begin
                    ghp_pkg::rsp_t want;
                    want = pending_results.pop_front();
                    if (out_item.ok !== want.ok)
                        note_mismatch("ok", ghp_pkg::GEN_W'(want.ok),
                                      ghp_pkg::GEN_W'(out_item.ok));
                    if (out_item.out_index !== want.out_index)
                        note_mismatch("out_index", ghp_pkg::GEN_W'(want.out_index),
                                      ghp_pkg::GEN_W'(out_item.out_index));
                    if (out_item.out_generation !== want.out_generation)
                        note_mismatch("out_generation", want.out_generation,
                                      out_item.out_generation);
                    if (out_item.live_count !== want.live_count)
                        note_mismatch("live_count", ghp_pkg::GEN_W'(want.live_count),
                                      ghp_pkg::GEN_W'(out_item.live_count));
                end
            end
            if (recv_gap > 0) begin
                out_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int total;
        int phase_no;
        int create_pct;
        int n;
        for (int i = 0; i < SLOTS; i++) begin
            slot_alive[i] = 1'b0;
            slot_gen[i] = '0;
        end
        live_slots = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty pool, then basic lifecycle and bad handles
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd0, 32'd0));
        push_request(make_req(ghp_pkg::OP_DESTROY, 8'd0, 32'd1));
        push_request(make_req(ghp_pkg::OP_CREATE, 8'd255, 32'hFFFF_FFFF));
        push_request(make_req(ghp_pkg::OP_CREATE, 8'd0, 32'd0));
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd0, 32'd1));
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd0, 32'd0));
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd64, 32'd1));
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd255, 32'hFFFF_FFFF));
        push_request(make_req(ghp_pkg::OP_DESTROY, 8'd0, 32'd2));
        push_request(make_req(ghp_pkg::OP_DESTROY, 8'd200, 32'd1));
        push_request(make_req(ghp_pkg::OP_DESTROY, 8'd0, 32'd1));
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd0, 32'd1));
        push_request(make_req(ghp_pkg::OP_DESTROY, 8'd0, 32'd1));
        push_request(make_req(ghp_pkg::OP_CREATE, 8'd0, 32'd0));
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd0, 32'd3));
        push_request(make_req(OP_UNUSED, 8'd255, 32'hFFFF_FFFF));
        push_request(make_req(OP_UNUSED, 8'd0, 32'd0));
        push_request(make_req(ghp_pkg::OP_DESTROY, 8'd1, 32'd1));
        push_request(make_req(ghp_pkg::OP_CREATE, 8'd0, 32'd0));
        push_request(make_req(ghp_pkg::OP_CREATE, 8'd0, 32'd0));
        push_request(make_req(ghp_pkg::OP_CHECK, 8'd2, 32'd1));

        // mix filling, balanced and draining phases in random order; the first one is a filling phase
        total = 0;
        phase_no = 0;
        while (total < RANDOM_ITEMS) begin
            case ($urandom_range(2))
                0: create_pct = 85;
                1: create_pct = 50;
                default: create_pct = 15;
            endcase
            if (phase_no == 0)
                create_pct = 85;
            quiet = ($urandom_range(3) == 0);
            n = $urandom_range(40, 120);
            for (int k = 0; k < n && total < RANDOM_ITEMS; k++) begin
                push_random_request(create_pct);
                total++;
            end
            phase_no++;
        end

        // sample between edges so the driver's updates have settled
        while (pending_requests.size() > 0 || in_valid)
            @(negedge clk);
        while (pending_results.size() > 0)
            @(negedge clk);
        repeat (SLOTS + 16) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
